// ----- design/rlcmc_pkg.sv -----
// ----------------------------------------------------------------------------
// rlcmc_pkg
// Shared types, constants and helpers for the run-length constrained
// minimum repaint cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package rlcmc_pkg;

   localparam int MAX_RUN    = 64;
   localparam int GROUP      = 8;
   localparam int NUM_GROUPS = MAX_RUN / GROUP;
   localparam int COST_W     = 21;
   localparam int PIX_W      = 11;
   localparam int RUN_W      = 7;
   localparam int CSR_IDX_W  = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RUN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RUN = 1'b1;

   typedef logic [COST_W-1:0] cost_type;

   localparam cost_type COST_INF = '1;

   typedef struct packed {
      logic             first_column;
      logic             last_column;
      logic [PIX_W-1:0] black_pixels;
      logic [PIX_W-1:0] white_pixels;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] min_cost;
      logic              no_solution;
   } rsp_type;

   typedef struct packed {
      logic init;
      logic shift;
   } cell_ctrl_type;

   // saturating add; infinity stays infinity
   function automatic cost_type sat_add(cost_type a, logic [PIX_W-1:0] b);
      logic [COST_W:0] s;
      s = {1'b0, a} + {{(COST_W + 1 - PIX_W){1'b0}}, b};
      if (a == COST_INF || s >= {1'b0, COST_INF}) begin
         return COST_INF;
      end
      return s[COST_W-1:0];
   endfunction

   function automatic cost_type min2(cost_type a, cost_type b);
      return (a < b) ? a : b;
   endfunction

endpackage

`default_nettype wire

// ----- design/rlcmc_cell.sv -----
// ----------------------------------------------------------------------------
// rlcmc_cell
// One run length slot: holds the best white-ending and black-ending cost and
// takes its neighbor's cost plus this column's repaint cost on a shift.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcmc_cell (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire rlcmc_pkg::cell_ctrl_type    ctrl,
   input  wire rlcmc_pkg::cost_type         init_w,
   input  wire rlcmc_pkg::cost_type         init_b,
   input  wire rlcmc_pkg::cost_type         feed_w,
   input  wire rlcmc_pkg::cost_type         feed_b,
   input  wire logic [rlcmc_pkg::PIX_W-1:0] add_w,
   input  wire logic [rlcmc_pkg::PIX_W-1:0] add_b,
   input  wire logic                        ext_ok,
   input  wire logic                        in_window,
   output rlcmc_pkg::cost_type              cost_w,
   output rlcmc_pkg::cost_type              cost_b,
   output rlcmc_pkg::cost_type              win_w,
   output rlcmc_pkg::cost_type              win_b
);

   rlcmc_pkg::cost_type w_ff, w_in;
   rlcmc_pkg::cost_type b_ff, b_in;

   always_comb begin
      w_in = w_ff;
      b_in = b_ff;
      if (ctrl.init) begin
         w_in = init_w;
         b_in = init_b;
      end else if (ctrl.shift) begin
         w_in = ext_ok ? rlcmc_pkg::sat_add(feed_w, add_w) : rlcmc_pkg::COST_INF;
         b_in = ext_ok ? rlcmc_pkg::sat_add(feed_b, add_b) : rlcmc_pkg::COST_INF;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_ff <= rlcmc_pkg::COST_INF;
         b_ff <= rlcmc_pkg::COST_INF;
      end else begin
         w_ff <= w_in;
         b_ff <= b_in;
      end
   end

   assign cost_w = w_ff;
   assign cost_b = b_ff;
   assign win_w  = in_window ? w_ff : rlcmc_pkg::COST_INF;
   assign win_b  = in_window ? b_ff : rlcmc_pkg::COST_INF;

endmodule

`default_nettype wire

// ----- design/rlcmc_min_tree.sv -----
// ----------------------------------------------------------------------------
// rlcmc_min_tree
// Two-level minimum over the windowed cell costs: group minima are
// registered, the final minimum of the groups is combinational.
// ----------------------------------------------------------------------------
`default_nettype none

module rlcmc_min_tree (
   input  wire logic                clock,
   input  wire rlcmc_pkg::cost_type win_w [rlcmc_pkg::MAX_RUN],
   input  wire rlcmc_pkg::cost_type win_b [rlcmc_pkg::MAX_RUN],
   output rlcmc_pkg::cost_type      min_w,
   output rlcmc_pkg::cost_type      min_b
);

   rlcmc_pkg::cost_type grp_w_ff [rlcmc_pkg::NUM_GROUPS];
   rlcmc_pkg::cost_type grp_b_ff [rlcmc_pkg::NUM_GROUPS];
   rlcmc_pkg::cost_type grp_w_in [rlcmc_pkg::NUM_GROUPS];
   rlcmc_pkg::cost_type grp_b_in [rlcmc_pkg::NUM_GROUPS];

   always_comb begin
      for (int g = 0; g < rlcmc_pkg::NUM_GROUPS; g++) begin
         grp_w_in[g] = rlcmc_pkg::COST_INF;
         grp_b_in[g] = rlcmc_pkg::COST_INF;
         for (int i = 0; i < rlcmc_pkg::GROUP; i++) begin
            grp_w_in[g] = rlcmc_pkg::min2(grp_w_in[g], win_w[g*rlcmc_pkg::GROUP + i]);
            grp_b_in[g] = rlcmc_pkg::min2(grp_b_in[g], win_b[g*rlcmc_pkg::GROUP + i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      grp_w_ff <= grp_w_in;
      grp_b_ff <= grp_b_in;
   end

   always_comb begin
      min_w = rlcmc_pkg::COST_INF;
      min_b = rlcmc_pkg::COST_INF;
      for (int g = 0; g < rlcmc_pkg::NUM_GROUPS; g++) begin
         min_w = rlcmc_pkg::min2(min_w, grp_w_ff[g]);
         min_b = rlcmc_pkg::min2(min_b, grp_b_ff[g]);
      end
   end

endmodule

`default_nettype wire

// ----- design/run_length_constrained_min_cost.sv -----
// ----------------------------------------------------------------------------
// run_length_constrained_min_cost
// Column-serial minimum repaint cost for black/white stripe patterns with
// bounded stripe widths.
// ----------------------------------------------------------------------------
// A first_column request initialises the cells when accepted; any other
// column goes through the TREE_A and UPD states, because the cost of starting
// a new stripe depends on the minimum over the current run table, which passes
// through a two-level registered minimum tree before the row of 64 run-length
// cells shifts. A last_column request adds TREE_B, a second pass of the tree
// over the updated table, then the answer goes to the response register; the
// block accepts the next request while that answer waits to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module run_length_constrained_min_cost (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire rlcmc_pkg::req_type              req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output rlcmc_pkg::rsp_type                   rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rlcmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [rlcmc_pkg::RUN_W-1:0]     csr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_TREE_A = 3'd1;
   localparam logic [2:0] ST_UPD    = 3'd2;
   localparam logic [2:0] ST_TREE_B = 3'd3;
   localparam logic [2:0] ST_OUT    = 3'd4;

   logic [2:0] state_ff, state_in;
   logic [rlcmc_pkg::RUN_W-1:0] min_run_ff, max_run_ff;
   logic [rlcmc_pkg::RUN_W-1:0] lo, hi;
   rlcmc_pkg::req_type col_ff;
   logic rsp_valid_ff, rsp_valid_in;
   rlcmc_pkg::rsp_type rsp_data_ff;
   logic req_accept, rsp_load;
   rlcmc_pkg::cell_ctrl_type cell_ctrl;

   rlcmc_pkg::cost_type cost_w [rlcmc_pkg::MAX_RUN];
   rlcmc_pkg::cost_type cost_b [rlcmc_pkg::MAX_RUN];
   rlcmc_pkg::cost_type win_w  [rlcmc_pkg::MAX_RUN];
   rlcmc_pkg::cost_type win_b  [rlcmc_pkg::MAX_RUN];
   rlcmc_pkg::cost_type min_w, min_b, best;

   // configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_run_ff <= rlcmc_pkg::RUN_W'(1);
         max_run_ff <= rlcmc_pkg::RUN_W'(rlcmc_pkg::MAX_RUN);
      end else if (csr_valid) begin
         unique case (csr_index)
            rlcmc_pkg::CSR_MIN_RUN: min_run_ff <= csr_data;
            rlcmc_pkg::CSR_MAX_RUN: max_run_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign lo = (min_run_ff == '0) ? rlcmc_pkg::RUN_W'(1) : min_run_ff;
   assign hi = (max_run_ff > rlcmc_pkg::RUN_W'(rlcmc_pkg::MAX_RUN))
             ? rlcmc_pkg::RUN_W'(rlcmc_pkg::MAX_RUN) : max_run_ff;

   // sequencing
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_load   = (state_ff == ST_OUT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (!req_data.first_column) begin
                  state_in = ST_TREE_A;
               end else if (req_data.last_column) begin
                  state_in = ST_TREE_B;
               end
            end
         end
         ST_TREE_A: state_in = ST_UPD;
         ST_UPD:    state_in = col_ff.last_column ? ST_TREE_B : ST_IDLE;
         ST_TREE_B: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         col_ff <= req_data;
      end
   end

   assign cell_ctrl.init  = req_accept && req_data.first_column;
   assign cell_ctrl.shift = (state_ff == ST_UPD);

   // run-length cell row
   for (genvar k = 0; k < rlcmc_pkg::MAX_RUN; k++) begin : g_cell
      localparam logic [rlcmc_pkg::RUN_W-1:0] POS = rlcmc_pkg::RUN_W'(k + 1);
      rlcmc_pkg::cost_type init_w, init_b, feed_w, feed_b;
      logic ext_ok, in_window;

      if (k == 0) begin : g_head
         // a new run starts from the best finished run of the other color
         assign init_w = rlcmc_pkg::COST_W'(req_data.black_pixels);
         assign init_b = rlcmc_pkg::COST_W'(req_data.white_pixels);
         assign feed_w = min_b;
         assign feed_b = min_w;
         assign ext_ok = 1'b1;
      end else begin : g_body
         assign init_w = rlcmc_pkg::COST_INF;
         assign init_b = rlcmc_pkg::COST_INF;
         assign feed_w = cost_w[k-1];
         assign feed_b = cost_b[k-1];
         assign ext_ok = (POS <= hi);
      end

      assign in_window = (POS >= lo) && (POS <= hi);

      rlcmc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (cell_ctrl),
         .init_w    (init_w),
         .init_b    (init_b),
         .feed_w    (feed_w),
         .feed_b    (feed_b),
         .add_w     (col_ff.black_pixels),
         .add_b     (col_ff.white_pixels),
         .ext_ok    (ext_ok),
         .in_window (in_window),
         .cost_w    (cost_w[k]),
         .cost_b    (cost_b[k]),
         .win_w     (win_w[k]),
         .win_b     (win_b[k])
      );
   end

   rlcmc_min_tree u_min_tree (
      .clock (clock),
      .win_w (win_w),
      .win_b (win_b),
      .min_w (min_w),
      .min_b (min_b)
   );

   // response register
   assign best = rlcmc_pkg::min2(min_w, min_b);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.no_solution <= (best == rlcmc_pkg::COST_INF);
         rsp_data_ff.min_cost    <= (best == rlcmc_pkg::COST_INF) ? '0 : best;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Checks the stripe repaint cost block: columns go in through the request
// channel and answers are matched against an in-bench model of the run-length
// tables, under several sender/receiver idle patterns and run-width settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

   localparam int LIMIT = 300000;

   typedef enum {ROW_COLUMN, ROW_RUNS} row_kind_type;

   typedef struct {
      row_kind_type                    kind;
      rlcmc_pkg::req_type              col;
      bit                              typed;
      rlcmc_pkg::rsp_type              want;
      logic [rlcmc_pkg::RUN_W-1:0]     lo;
      logic [rlcmc_pkg::RUN_W-1:0]     hi;
   } stim_row_type;

   logic                            clock;
   logic                            reset     = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   rlcmc_pkg::req_type              req_data  = '0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   rlcmc_pkg::rsp_type              rsp_data;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [rlcmc_pkg::CSR_IDX_W-1:0] csr_index = rlcmc_pkg::CSR_MIN_RUN;
   logic [rlcmc_pkg::RUN_W-1:0]     csr_data  = '0;

   // model state
   rlcmc_pkg::cost_type         paint_white_best [rlcmc_pkg::MAX_RUN];
   rlcmc_pkg::cost_type         paint_black_best [rlcmc_pkg::MAX_RUN];
   logic [rlcmc_pkg::RUN_W-1:0] cfg_min_width = 7'd1;
   logic [rlcmc_pkg::RUN_W-1:0] cfg_max_width = 7'd64;

   rlcmc_pkg::rsp_type pending_answers [$];
   stim_row_type       directed [$];
   int                 failures       = 0;
   int                 columns_sent   = 0;
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 cycle_count    = 0;

   run_length_constrained_min_cost u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= LIMIT);
      $display("[run_length_constrained_min_cost] ERROR");
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   function automatic void add_row(input stim_row_type r);
      directed.insert(directed.size(), r);
   endfunction

   function automatic rlcmc_pkg::cost_type cost_plus(rlcmc_pkg::cost_type base,
                                                     logic [rlcmc_pkg::PIX_W-1:0] add);
      logic [rlcmc_pkg::COST_W:0] s;
      s = {1'b0, base} + {{(rlcmc_pkg::COST_W + 1 - rlcmc_pkg::PIX_W){1'b0}}, add};
      if (base == rlcmc_pkg::COST_INF || s >= {1'b0, rlcmc_pkg::COST_INF}) begin
         return rlcmc_pkg::COST_INF;
      end
      return s[rlcmc_pkg::COST_W-1:0];
   endfunction

   // one column through the run tables; returns 1 when an answer is due
   function automatic bit advance_column(input rlcmc_pkg::req_type col,
                                         output rlcmc_pkg::rsp_type ans);
      int                  lo_w;
      int                  hi_w;
      rlcmc_pkg::cost_type nw [rlcmc_pkg::MAX_RUN];
      rlcmc_pkg::cost_type nb [rlcmc_pkg::MAX_RUN];
      rlcmc_pkg::cost_type best;
      rlcmc_pkg::cost_type c;
      lo_w = (cfg_min_width == 0) ? 1 : int'(cfg_min_width);
      hi_w = (cfg_max_width > rlcmc_pkg::MAX_RUN) ? rlcmc_pkg::MAX_RUN : int'(cfg_max_width);
      for (int k = 0; k < rlcmc_pkg::MAX_RUN; k++) begin
         nw[k] = rlcmc_pkg::COST_INF;
         nb[k] = rlcmc_pkg::COST_INF;
      end
      if (col.first_column) begin
         nw[0] = rlcmc_pkg::cost_type'(col.black_pixels);
         nb[0] = rlcmc_pkg::cost_type'(col.white_pixels);
      end else begin
         for (int j = 1; j <= hi_w; j++) begin
            if (j < hi_w) begin
               nw[j] = cost_plus(paint_white_best[j-1], col.black_pixels);
               nb[j] = cost_plus(paint_black_best[j-1], col.white_pixels);
            end
            // run of width j may end here and switch color
            if (j >= lo_w) begin
               c = cost_plus(paint_white_best[j-1], col.white_pixels);
               if (c < nb[0]) nb[0] = c;
               c = cost_plus(paint_black_best[j-1], col.black_pixels);
               if (c < nw[0]) nw[0] = c;
            end
         end
      end
      paint_white_best = nw;
      paint_black_best = nb;
      best = rlcmc_pkg::COST_INF;
      for (int j = lo_w; j <= hi_w; j++) begin
         if (paint_white_best[j-1] < best) best = paint_white_best[j-1];
         if (paint_black_best[j-1] < best) best = paint_black_best[j-1];
      end
      ans.no_solution = (best == rlcmc_pkg::COST_INF);
      ans.min_cost    = ans.no_solution ? '0 : best;
      return col.last_column;
   endfunction

   function automatic stim_row_type column_row(bit f, bit l, int black, int white);
      stim_row_type r;
      r.kind             = ROW_COLUMN;
      r.col.first_column = f;
      r.col.last_column  = l;
      r.col.black_pixels = rlcmc_pkg::PIX_W'(black);
      r.col.white_pixels = rlcmc_pkg::PIX_W'(white);
      r.typed            = 1'b0;
      r.want             = '0;
      r.lo               = '0;
      r.hi               = '0;
      return r;
   endfunction

   function automatic stim_row_type answer_row(bit f, bit l, int black, int white,
                                               int cost, bit none);
      stim_row_type r;
      r                  = column_row(f, l, black, white);
      r.typed            = 1'b1;
      r.want.min_cost    = rlcmc_pkg::COST_W'(cost);
      r.want.no_solution = none;
      return r;
   endfunction

   function automatic stim_row_type runs_row(int lo, int hi);
      stim_row_type r;
      r      = column_row(1'b0, 1'b0, 0, 0);
      r.kind = ROW_RUNS;
      r.lo   = rlcmc_pkg::RUN_W'(lo);
      r.hi   = rlcmc_pkg::RUN_W'(hi);
      return r;
   endfunction

   function automatic logic [rlcmc_pkg::PIX_W-1:0] pixel_count();
      if ($urandom_range(99) < 15) return rlcmc_pkg::PIX_W'($urandom_range(0, 2047));
      return rlcmc_pkg::PIX_W'($urandom_range(0, 1024));
   endfunction

   function automatic logic [rlcmc_pkg::RUN_W-1:0] pick_width();
      case ($urandom_range(9))
         0:       return '0;
         1:       return 7'd64;
         2:       return rlcmc_pkg::RUN_W'($urandom_range(65, 127));
         3, 4, 5: return rlcmc_pkg::RUN_W'($urandom_range(1, 4));
         6, 7:    return rlcmc_pkg::RUN_W'($urandom_range(5, 16));
         default: return rlcmc_pkg::RUN_W'($urandom_range(1, 64));
      endcase
   endfunction

   // entered and left at a falling edge
   task automatic drive_column(input rlcmc_pkg::req_type col, input bit typed,
                               input rlcmc_pkg::rsp_type want);
      int                 gap;
      rlcmc_pkg::rsp_type ans;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_data  <= col;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (advance_column(col, ans)) begin
         pending_answers.insert(pending_answers.size(), typed ? want : ans);
      end
      columns_sent++;
      @(negedge clock);
   endtask

   // hold requests until every answer is back, then let the pipe empty
   task automatic settle(input int tail);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (tail) @(negedge clock);
   endtask

   task automatic program_runs(input logic [rlcmc_pkg::RUN_W-1:0] lo,
                               input logic [rlcmc_pkg::RUN_W-1:0] hi);
      csr_valid <= 1'b1;
      csr_index <= rlcmc_pkg::CSR_MIN_RUN;
      csr_data  <= lo;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_min_width = lo;
      @(negedge clock);
      csr_index <= rlcmc_pkg::CSR_MAX_RUN;
      csr_data  <= hi;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_max_width = hi;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      rlcmc_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected answer: expected none, got cost=%0d no_solution=%0b",
                     $time, rsp_data.min_cost, rsp_data.no_solution);
            failures++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.min_cost !== want.min_cost) begin
               $display("%0t: min_cost mismatch: expected %0d, got %0d",
                        $time, want.min_cost, rsp_data.min_cost);
               failures++;
            end
            if (rsp_data.no_solution !== want.no_solution) begin
               $display("%0t: no_solution mismatch: expected %0b, got %0b",
                        $time, want.no_solution, rsp_data.no_solution);
               failures++;
            end
         end
      end
   end

   initial begin
      rlcmc_pkg::req_type          col;
      rlcmc_pkg::rsp_type          none;
      logic [rlcmc_pkg::RUN_W-1:0] lo;
      logic [rlcmc_pkg::RUN_W-1:0] hi;
      int                          lo_e;
      int                          len;
      int                          shape;
      int                          budget;

      for (int k = 0; k < rlcmc_pkg::MAX_RUN; k++) begin
         paint_white_best[k] = rlcmc_pkg::COST_INF;
         paint_black_best[k] = rlcmc_pkg::COST_INF;
      end
      none = '0;

      // kind              first last black white  answer
      add_row(answer_row(0, 1,    5,    7,    0, 1)); // tables still empty
      add_row(answer_row(1, 1,    0,    0,    0, 0));
      add_row(answer_row(1, 1, 1024,    3,    3, 0));
      add_row(answer_row(1, 1, 2047, 2047, 2047, 0));
      add_row(column_row(1, 0,   10,    2));
      add_row(column_row(0, 0,    1,    9));
      add_row(column_row(0, 1,    4,    4));
      add_row(runs_row(2, 3));
      add_row(column_row(1, 0,    3,    5));
      add_row(column_row(0, 0,    6,    1));
      add_row(column_row(0, 0,    2,    2));
      add_row(column_row(0, 0,    7,    0));
      add_row(column_row(0, 1,    1,    8));
      add_row(column_row(0, 1,    2,    2)); // continues past the last column
      add_row(runs_row(5, 2));
      add_row(answer_row(1, 1,    9,    9,    0, 1)); // min above max
      add_row(runs_row(1, 0));
      add_row(answer_row(1, 1,    9,    9,    0, 1)); // no width allowed
      add_row(runs_row(0, 100));                     // treated as 1..64
      add_row(column_row(1, 0,   12,    4));
      add_row(column_row(0, 0,    0, 1024));
      add_row(column_row(0, 1,  700,  300));
      add_row(runs_row(1, 64));
      add_row(column_row(1, 0,    4,    6));
      add_row(column_row(0, 0,    5,    5));
      add_row(runs_row(1, 1));                       // change inside an image
      add_row(column_row(0, 1,    3,    2));
      add_row(runs_row(127, 127));
      add_row(answer_row(1, 1,    0,    0,    0, 1));

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_RUNS) begin
            settle(8);
            program_runs(directed[i].lo, directed[i].hi);
         end else begin
            drive_column(directed[i].col, directed[i].typed, directed[i].want);
         end
      end

      // long image of near-full columns: the running cost saturates
      settle(8);
      program_runs(7'd1, 7'd64);
      for (int k = 0; k < 1030; k++) begin
         col.first_column = (k == 0);
         col.last_column  = (k == 1029);
         col.black_pixels = rlcmc_pkg::PIX_W'($urandom_range(2046, 2047));
         col.white_pixels = rlcmc_pkg::PIX_W'($urandom_range(2046, 2047));
         drive_column(col, 1'b0, none);
      end

      for (int phase = 0; phase < 12; phase++) begin
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
            default: begin send_idle_pct = 17; recv_stall_pct = 17; end
         endcase
         settle(8);
         lo = pick_width();
         if ($urandom_range(9) < 6) begin
            hi = (int'(lo) + 8 > 127) ? 7'd127 : lo + rlcmc_pkg::RUN_W'($urandom_range(0, 8));
         end else begin
            hi = pick_width();
         end
         program_runs(lo, hi);
         lo_e   = (lo == 0) ? 1 : ((lo > rlcmc_pkg::MAX_RUN) ? rlcmc_pkg::MAX_RUN : int'(lo));
         budget = columns_sent + 50;
         while (columns_sent < budget) begin
            if ($urandom_range(9) < 8) len = $urandom_range(1, 2 * lo_e + 4);
            else len = $urandom_range(1, 6);
            // mostly well-formed images; a few lack a mark or carry stray ones
            shape = $urandom_range(19);
            for (int k = 0; k < len; k++) begin
               col.black_pixels = pixel_count();
               col.white_pixels = pixel_count();
               if (shape == 2) begin
                  col.first_column = ($urandom_range(9) == 0);
                  col.last_column  = ($urandom_range(9) == 0);
               end else begin
                  col.first_column = (k == 0) && (shape != 0);
                  col.last_column  = (k == len - 1) && (shape != 1);
               end
               drive_column(col, 1'b0, none);
            end
            if ($urandom_range(7) == 0) settle(1);
         end
      end

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      settle(20);
      if (failures == 0 && pending_answers.size() == 0) begin
         $display("[run_length_constrained_min_cost] OK");
      end else begin
         $display("[run_length_constrained_min_cost] ERROR");
      end
      $finish;
   end

endmodule
